>>> rtl/keg_pkg.sv
// ============================================================================
// keg_pkg
// Shared types and constants for the key event edge guard: binding register
// layout, source codes, configuration register indexes and default sizes.
// ============================================================================
`default_nettype none

package keg_pkg;

    // Default sizes
    localparam int EVENT_COUNT_DEF   = 6;
    localparam int BINDING_COUNT_DEF = 6;

    // Field widths
    localparam int LEVEL_W     = 8;
    localparam int TICK_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int BIND_W      = 13;
    localparam int EVT_W       = 3;

    // Binding source codes
    typedef enum logic [1:0] {
        SRC_PORT1 = 2'd0,
        SRC_PORT2 = 2'd1,
        SRC_TOUCH = 2'd2,
        SRC_NONE  = 2'd3
    } t_src;

    // Binding register layout: event, mask or channel, source
    typedef struct packed {
        logic [EVT_W-1:0]   evt;
        logic [LEVEL_W-1:0] id;
        t_src               src;
    } t_binding;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GUARD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BINDING_0 = 3'd1;

endpackage

`default_nettype wire

>>> rtl/key_event_edge_guard.sv
// ============================================================================
// key_event_edge_guard
// Press edge detector with a per-event repeat guard over six bindings.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one debounced sample:
//   two active-low port levels, two touch masks and the current tick.
//   Output channel (o_out_valid / i_out_ready) returns one event mask per
//   sample, in order.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data):
//   index 0 is the guard tick count, indexes 1..BINDING_COUNT the bindings.
//   Write it only while no sample is in flight.
//   Path: an accepted sample is held in the input register, evaluated from
//   there and captured in the result register once that slot is free.
//   Throughput: one sample per cycle; the input register and the result
//   register each take a new transaction as the stage after them moves on.
//   The path is set by the six binding matches and the 16-bit guard compare.
//   Reset clears the bindings, guard, previous press state, fired flags and
//   both valid flags. When the receiver stalls, the result holds, one more
//   sample waits in the input register, and then o_in_ready drops.
// ============================================================================
`default_nettype none

module key_event_edge_guard
    import keg_pkg::*;
#(
    parameter int EVENT_COUNT   = EVENT_COUNT_DEF,
    parameter int BINDING_COUNT = BINDING_COUNT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // sample channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [LEVEL_W-1:0]     i_port1_level,
    input  wire logic [LEVEL_W-1:0]     i_port2_level,
    input  wire logic [LEVEL_W-1:0]     i_touch_first,
    input  wire logic [LEVEL_W-1:0]     i_touch_second,
    input  wire logic [TICK_W-1:0]      i_now_tick,
    // event channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [EVENT_COUNT-1:0]      o_event_mask
);

    // Configuration registers
    logic [TICK_W-1:0] r_guard_ticks;
    t_binding          r_binding [BINDING_COUNT];

    // Input register
    logic               r_in_valid;
    logic [LEVEL_W-1:0] r_port1;
    logic [LEVEL_W-1:0] r_port2;
    logic [LEVEL_W-1:0] r_touch_a;
    logic [LEVEL_W-1:0] r_touch_b;
    logic [TICK_W-1:0]  r_now;

    // Press history and guard state
    logic [LEVEL_W-1:0]     r_prev_port1;
    logic [LEVEL_W-1:0]     r_prev_port2;
    logic [LEVEL_W-1:0]     r_prev_touch;
    logic [EVENT_COUNT-1:0] r_fired_once;
    logic [TICK_W-1:0]      r_fire_stamp [EVENT_COUNT];

    // Result register
    logic                   r_out_valid;
    logic [EVENT_COUNT-1:0] r_event_mask;

    // Evaluation
    logic [LEVEL_W-1:0]       n_prev_port1;
    logic [LEVEL_W-1:0]       n_prev_port2;
    logic [LEVEL_W-1:0]       n_prev_touch;
    logic [EVENT_COUNT-1:0]   n_fire;
    logic [BINDING_COUNT-1:0] w_hit;
    logic                     w_adv;

    // Handshake: the input register moves on when the result slot frees up
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_event_mask = r_event_mask;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_ticks <= '0;
            for (int b = 0; b < BINDING_COUNT; b++) begin
                r_binding[b] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_GUARD) begin
                r_guard_ticks <= i_cfg_data[TICK_W-1:0];
            end
            for (int b = 0; b < BINDING_COUNT; b++) begin
                if (i_cfg_index == CFG_BINDING_0 + CFG_INDEX_W'(b)) begin
                    r_binding[b] <= t_binding'(i_cfg_data[BIND_W-1:0]);
                end
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_port1   <= i_port1_level;
            r_port2   <= i_port2_level;
            r_touch_a <= i_touch_first;
            r_touch_b <= i_touch_second;
            r_now     <= i_now_tick;
        end
    end

    // Pressed levels and new press edges, then binding matches
    always_comb begin
        logic [LEVEL_W-1:0] mask1;
        logic [LEVEL_W-1:0] mask2;
        logic [LEVEL_W-1:0] new1;
        logic [LEVEL_W-1:0] new2;
        logic [LEVEL_W-1:0] newt;
        mask1 = '0;
        mask2 = '0;
        for (int b = 0; b < BINDING_COUNT; b++) begin
            if (r_binding[b].src == SRC_PORT1) begin
                mask1 = mask1 | r_binding[b].id;
            end
            if (r_binding[b].src == SRC_PORT2) begin
                mask2 = mask2 | r_binding[b].id;
            end
        end
        n_prev_port1 = ~r_port1 & mask1;
        n_prev_port2 = ~r_port2 & mask2;
        n_prev_touch = r_touch_a | r_touch_b;
        new1 = n_prev_port1 & ~r_prev_port1;
        new2 = n_prev_port2 & ~r_prev_port2;
        newt = n_prev_touch & ~r_prev_touch;
        for (int b = 0; b < BINDING_COUNT; b++) begin
            case (r_binding[b].src)
                SRC_PORT1: w_hit[b] = |(new1 & r_binding[b].id);
                SRC_PORT2: w_hit[b] = |(new2 & r_binding[b].id);
                // channel numbers above 7 never match
                SRC_TOUCH: w_hit[b] = (r_binding[b].id[LEVEL_W-1:3] == '0)
                                      && newt[r_binding[b].id[2:0]];
                default:   w_hit[b] = 1'b0;
            endcase
        end
    end

    // Per event: any matching binding, and either no earlier fire or the guard window has passed
    always_comb begin
        logic              any_hit;
        logic [TICK_W-1:0] diff;
        for (int e = 0; e < EVENT_COUNT; e++) begin
            any_hit = 1'b0;
            for (int b = 0; b < BINDING_COUNT; b++) begin
                if (w_hit[b] && (r_binding[b].evt == EVT_W'(e))) begin
                    any_hit = 1'b1;
                end
            end
            diff      = r_now - r_fire_stamp[e];
            n_fire[e] = any_hit && (!r_fired_once[e] || (diff >= r_guard_ticks));
        end
    end

    // State update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_port1 <= '0;
            r_prev_port2 <= '0;
            r_prev_touch <= '0;
            r_fired_once <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_prev_port1 <= n_prev_port1;
                r_prev_port2 <= n_prev_port2;
                r_prev_touch <= n_prev_touch;
                r_fired_once <= r_fired_once | n_fire;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Stamps only matter once the fired flag is set
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_event_mask <= n_fire;
            for (int e = 0; e < EVENT_COUNT; e++) begin
                if (n_fire[e]) begin
                    r_fire_stamp[e] <= r_now;
                end
            end
        end
    end

    // Assertions
    a_fired_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((~r_fired_once & $past(r_fired_once)) == '0))
        else $error("fired flag cleared outside reset");

    a_fire_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> ((r_fired_once & $past(n_fire)) == $past(n_fire)))
        else $error("fired event not recorded");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a pending sample");

    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted sample lost");

endmodule

`default_nettype wire

>>> verif/keg_tb_pkg.sv
// ----------------------------------------------------------------------------
// keg_tb_pkg
// Scoreboard for the key event edge guard bench. It tracks the register
// settings and the press history, predicts the event mask of every accepted
// sample and checks the returned masks in order.
// ----------------------------------------------------------------------------
package keg_tb_pkg;

    import keg_pkg::*;

    class keg_event_scoreboard;

        // register copies
        logic [TICK_W-1:0]          guard_ticks;
        t_binding                   bindings [BINDING_COUNT_DEF];

        // press history
        logic [LEVEL_W-1:0]         last_port1;
        logic [LEVEL_W-1:0]         last_port2;
        logic [LEVEL_W-1:0]         last_touch;
        logic [EVENT_COUNT_DEF-1:0] fired_once;
        logic [TICK_W-1:0]          fire_stamp [EVENT_COUNT_DEF];

        logic [EVENT_COUNT_DEF-1:0] expected_masks [$];
        int                         errors;
        int                         masks_checked;
        int                         fire_count;

        function new();
            guard_ticks   = '0;
            last_port1    = '0;
            last_port2    = '0;
            last_touch    = '0;
            fired_once    = '0;
            errors        = 0;
            masks_checked = 0;
            fire_count    = 0;
            foreach (bindings[i]) bindings[i] = '0;
            foreach (fire_stamp[i]) fire_stamp[i] = '0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
            if (index == CFG_GUARD) begin
                guard_ticks = data;
            end else if (index >= CFG_BINDING_0 && index < CFG_BINDING_0 + BINDING_COUNT_DEF) begin
                bindings[index - CFG_BINDING_0] = t_binding'(data[BIND_W-1:0]);
            end
        endfunction

        // Notes an accepted sample, updates the press history and queues the
        // event mask that sample must produce.
        function void predict_event_mask(input logic [LEVEL_W-1:0] port1,
                                         input logic [LEVEL_W-1:0] port2,
                                         input logic [LEVEL_W-1:0] touch_a,
                                         input logic [LEVEL_W-1:0] touch_b,
                                         input logic [TICK_W-1:0]  tick);
            logic [LEVEL_W-1:0]         mask1;
            logic [LEVEL_W-1:0]         mask2;
            logic [LEVEL_W-1:0]         pressed1;
            logic [LEVEL_W-1:0]         pressed2;
            logic [LEVEL_W-1:0]         touched;
            logic [LEVEL_W-1:0]         new1;
            logic [LEVEL_W-1:0]         new2;
            logic [LEVEL_W-1:0]         newt;
            logic [EVENT_COUNT_DEF-1:0] events;
            logic [TICK_W-1:0]          elapsed;
            logic                       hit;
            t_binding                   b;

            mask1  = '0;
            mask2  = '0;
            events = '0;

            // port bits named by any binding of that port
            foreach (bindings[i]) begin
                if (bindings[i].src == SRC_PORT1) mask1 |= bindings[i].id;
                if (bindings[i].src == SRC_PORT2) mask2 |= bindings[i].id;
            end

            pressed1 = ~port1 & mask1;
            pressed2 = ~port2 & mask2;
            touched  = touch_a | touch_b;
            new1     = pressed1 & ~last_port1;
            new2     = pressed2 & ~last_port2;
            newt     = touched & ~last_touch;

            // bindings in order; once an event fires, later hits on it are skipped
            for (int i = 0; i < BINDING_COUNT_DEF; i++) begin
                b = bindings[i];
                case (b.src)
                    SRC_PORT1: hit = |(new1 & b.id);
                    SRC_PORT2: hit = |(new2 & b.id);
                    SRC_TOUCH: hit = (b.id < LEVEL_W) && newt[b.id[2:0]];
                    default:   hit = 1'b0;
                endcase
                if (hit && b.evt < EVENT_COUNT_DEF && !events[b.evt]) begin
                    elapsed = tick - fire_stamp[b.evt];
                    if (!fired_once[b.evt] || elapsed >= guard_ticks) begin
                        fired_once[b.evt] = 1'b1;
                        fire_stamp[b.evt] = tick;
                        events[b.evt]     = 1'b1;
                        fire_count++;
                    end
                end
            end

            last_port1 = pressed1;
            last_port2 = pressed2;
            last_touch = touched;
            expected_masks.push_back(events);
        endfunction

        function void check_event_mask(input logic [EVENT_COUNT_DEF-1:0] actual);
            logic [EVENT_COUNT_DEF-1:0] want;
            if (expected_masks.size() == 0) begin
                $error("event_mask: none expected, actual %02h", actual);
                errors++;
            end else begin
                want = expected_masks.pop_front();
                masks_checked++;
                if (actual !== want) begin
                    $error("event_mask: expected %02h, actual %02h", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction

    endclass

endpackage

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for key_event_edge_guard. A directed part walks the binding sources,
// unused bindings, out-of-range channels and events, shared events, tick wrap
// and both guard extremes; random phases then reload all registers and drive
// toggling levels with creeping ticks, under random stalls on both channels in all phases but one.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import keg_pkg::*;
    import keg_tb_pkg::*;

    localparam int IDLE_PCT          = 17;
    localparam int RANDOM_PHASES     = 6;
    localparam int SAMPLES_PER_PHASE = 96;
    localparam int SETTLE_CYCLES     = 4;
    localparam int WATCHDOG_LIMIT    = 2000;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0]     i_cfg_index    = CFG_GUARD;
    logic [CFG_DATA_W-1:0]      i_cfg_data     = '0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_ready;
    logic [LEVEL_W-1:0]         i_port1_level  = '1;
    logic [LEVEL_W-1:0]         i_port2_level  = '1;
    logic [LEVEL_W-1:0]         i_touch_first  = '0;
    logic [LEVEL_W-1:0]         i_touch_second = '0;
    logic [TICK_W-1:0]          i_now_tick     = '0;
    logic                       o_out_valid;
    logic                       i_out_ready    = 1'b0;
    logic [EVENT_COUNT_DEF-1:0] o_event_mask;

    keg_event_scoreboard sb = new();

    bit       steady          = 1'b0;
    int       quiet_cycles    = 0;
    int       samples_sent    = 0;
    int       settings_loaded = 0;

    // register plan for the next load
    logic [TICK_W-1:0] plan_guard;
    t_binding          plan_binds [BINDING_COUNT_DEF];

    key_event_edge_guard uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_port1_level  (i_port1_level),
        .i_port2_level  (i_port2_level),
        .i_touch_first  (i_touch_first),
        .i_touch_second (i_touch_second),
        .i_now_tick     (i_now_tick),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_mask   (o_event_mask)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_event_mask(o_event_mask);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_binding bind_to(input t_src src, input logic [LEVEL_W-1:0] id,
                                         input logic [EVT_W-1:0] evt);
        t_binding b;
        b.src = src;
        b.id  = id;
        b.evt = evt;
        return b;
    endfunction

    // one sample transaction, with an optional gap in front
    task automatic send_sample(input logic [LEVEL_W-1:0] p1, input logic [LEVEL_W-1:0] p2,
                               input logic [LEVEL_W-1:0] t1, input logic [LEVEL_W-1:0] t2,
                               input logic [TICK_W-1:0] tick);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        i_in_valid     <= 1'b1;
        i_port1_level  <= p1;
        i_port2_level  <= p2;
        i_touch_first  <= t1;
        i_touch_second <= t2;
        i_now_tick     <= tick;
        do @(posedge i_clk); while (!o_in_ready);
        sb.predict_event_mask(p1, p2, t1, t2, tick);
        samples_sent++;
    endtask

    // stop sending and let every expected mask come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the guard and all bindings from the plan
    task automatic load_settings();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GUARD;
        i_cfg_data  <= plan_guard;
        @(posedge i_clk);
        sb.write_reg(CFG_GUARD, plan_guard);
        for (int i = 0; i < BINDING_COUNT_DEF; i++) begin
            i_cfg_index <= CFG_INDEX_W'(CFG_BINDING_0 + i);
            i_cfg_data  <= CFG_DATA_W'(plan_binds[i]);
            @(posedge i_clk);
            sb.write_reg(CFG_INDEX_W'(CFG_BINDING_0 + i), CFG_DATA_W'(plan_binds[i]));
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_loaded++;
    endtask

    initial begin
        logic [LEVEL_W-1:0] cur_p1;
        logic [LEVEL_W-1:0] cur_p2;
        logic [LEVEL_W-1:0] cur_t1;
        logic [LEVEL_W-1:0] cur_t2;
        logic [TICK_W-1:0]  cur_tick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero guard; every source, plus dead bindings of each kind
        plan_guard = '0;
        plan_binds = '{bind_to(SRC_PORT1, 8'h0F, 3'd0), bind_to(SRC_PORT2, 8'hF0, 3'd1),
                       bind_to(SRC_TOUCH, 8'd3, 3'd2),  bind_to(SRC_TOUCH, 8'd200, 3'd3),
                       bind_to(SRC_NONE, 8'hFF, 3'd4),  bind_to(SRC_PORT1, 8'h80, 3'd7)};
        load_settings();
        send_sample(8'hFF, 8'hFF, 8'h00, 8'h00, 16'h0000);
        send_sample(8'h00, 8'h00, 8'hFF, 8'h00, 16'hFFFF);
        send_sample(8'h00, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
        send_sample(8'hFF, 8'hFF, 8'h00, 8'h00, 16'h0000);
        send_sample(8'hFE, 8'h7F, 8'h00, 8'h08, 16'h0001);
        send_sample(8'h7F, 8'hFF, 8'h00, 8'h00, 16'h0002);
        wait_idle();

        // guard of 100, shared event, tick wrap, unnamed port bits
        plan_guard = 16'd100;
        plan_binds = '{bind_to(SRC_PORT1, 8'h01, 3'd5), bind_to(SRC_PORT2, 8'h01, 3'd5),
                       bind_to(SRC_TOUCH, 8'd0, 3'd5),  bind_to(SRC_TOUCH, 8'd7, 3'd0),
                       bind_to(SRC_PORT2, 8'h02, 3'd0), bind_to(SRC_PORT1, 8'h02, 3'd4)};
        load_settings();
        send_sample(8'hFF, 8'hFF, 8'h00, 8'h00, 16'd65500);
        send_sample(8'hFE, 8'hFE, 8'h01, 8'h00, 16'd65530);
        send_sample(8'hFF, 8'hFF, 8'h00, 8'h00, 16'd65531);
        send_sample(8'hFE, 8'hFF, 8'h00, 8'h00, 16'd40);
        send_sample(8'hFF, 8'hFF, 8'h00, 8'h00, 16'd41);
        send_sample(8'hFE, 8'hFF, 8'h00, 8'h00, 16'd94);
        send_sample(8'hFF, 8'hFD, 8'h80, 8'h00, 16'd95);
        send_sample(8'h03, 8'hFF, 8'h00, 8'h00, 16'd96);
        wait_idle();

        // maximum guard: only the largest tick difference lets an event fire again
        plan_guard = 16'hFFFF;
        plan_binds = '{bind_to(SRC_PORT1, 8'h01, 3'd3), bind_to(SRC_TOUCH, 8'd0, 3'd3),
                       bind_to(SRC_PORT2, 8'hFF, 3'd5), bind_to(SRC_NONE, 8'h00, 3'd0),
                       bind_to(SRC_TOUCH, 8'd255, 3'd1), bind_to(SRC_PORT2, 8'h01, 3'd6)};
        load_settings();
        send_sample(8'hFF, 8'hFF, 8'h00, 8'h00, 16'd1000);
        send_sample(8'hFE, 8'hFF, 8'hFF, 8'h01, 16'd1000);
        send_sample(8'hFF, 8'hFF, 8'h00, 8'h00, 16'd1001);
        send_sample(8'hFE, 8'hFF, 8'h00, 8'h00, 16'd1001);
        send_sample(8'hFF, 8'hFF, 8'h00, 8'h00, 16'd1002);
        send_sample(8'hFE, 8'h00, 8'h00, 8'h00, 16'd999);
        wait_idle();

        // random phases: fresh registers, toggling levels, creeping ticks
        cur_p1   = '1;
        cur_p2   = '1;
        cur_t1   = '0;
        cur_t2   = '0;
        cur_tick = TICK_W'($urandom);
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       plan_guard = '0;
                1:       plan_guard = '1;
                default: plan_guard = $urandom_range(0, 1) ? TICK_W'($urandom_range(0, 60))
                                                           : TICK_W'($urandom);
            endcase
            for (int i = 0; i < BINDING_COUNT_DEF; i++) begin
                plan_binds[i].src = t_src'($urandom_range(0, 3));
                plan_binds[i].id  = (plan_binds[i].src == SRC_TOUCH && $urandom_range(0, 3) != 0)
                                    ? LEVEL_W'($urandom_range(0, 7)) : LEVEL_W'($urandom);
                plan_binds[i].evt = ($urandom_range(0, 3) == 0) ? EVT_W'($urandom_range(0, 7))
                                                                : EVT_W'($urandom_range(0, 5));
            end
            load_settings();
            steady = (ph == 2);
            for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
                if (n == SAMPLES_PER_PHASE / 2) wait_idle();
                if ($urandom_range(0, 9) < 7) begin
                    // sparse bit flips give clean press and release edges
                    cur_p1 ^= LEVEL_W'($urandom) & LEVEL_W'($urandom) & LEVEL_W'($urandom);
                    cur_p2 ^= LEVEL_W'($urandom) & LEVEL_W'($urandom) & LEVEL_W'($urandom);
                    cur_t1 ^= LEVEL_W'($urandom) & LEVEL_W'($urandom) & LEVEL_W'($urandom);
                    cur_t2 ^= LEVEL_W'($urandom) & LEVEL_W'($urandom) & LEVEL_W'($urandom);
                end else begin
                    cur_p1 = LEVEL_W'($urandom);
                    cur_p2 = LEVEL_W'($urandom);
                    cur_t1 = LEVEL_W'($urandom);
                    cur_t2 = LEVEL_W'($urandom);
                end
                cur_tick = ($urandom_range(0, 9) < 8) ? cur_tick + TICK_W'($urandom_range(0, 60))
                                                      : TICK_W'($urandom);
                send_sample(cur_p1, cur_p2, cur_t1, cur_t2, cur_tick);
            end
            steady = 1'b0;
            wait_idle();
        end

        $display("Ran %0d samples across %0d register loads; %0d event masks compared.",
                 samples_sent, settings_loaded, sb.masks_checked);
        $display("Events fired in total: %0d; mismatches seen: %0d.", sb.fire_count, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
